// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, skipped while reset is high.
`define RMAR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property at every rising edge, reset included.
`define RMAR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/rmar_pkg.sv =====
package rmar_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int MED_W    = DATA_W + 1;

  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef struct packed {
    logic                     add;
    logic                     rem;
    logic                     remove_mode;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic ge;
    logic hit;
  } flag_t;

endpackage

// ===== rtl/rmar_cell.sv =====
module rmar_cell (
  input  logic                              clk,
  input  rmar_pkg::cmd_t                    cmd,
  input  logic                              live,
  input  logic                              left_ge,
  input  logic signed [rmar_pkg::DATA_W-1:0] left_data,
  input  logic signed [rmar_pkg::DATA_W-1:0] right_data,
  output logic signed [rmar_pkg::DATA_W-1:0] data,
  output rmar_pkg::flag_t                   flag
);

  logic ge;

  always_comb begin
    if (cmd.remove_mode) begin
      ge = live && (data >= cmd.value);
    end else begin
      ge = !live || (data > cmd.value);
    end
    flag.ge  = ge;
    flag.hit = live && ge && !left_ge && (data == cmd.value);
  end

  always_ff @(posedge clk) begin
    if (cmd.add && ge) begin
      data <= left_ge ? left_data : cmd.value;
    end else if (cmd.rem && ge) begin
      data <= right_data;
    end
  end

endmodule

// ===== rtl/running_median_add_remove_core.sv =====
// Running median over a sorted multiset of up to 64 signed 32-bit values. Each transaction
// adds a value (action 0) or removes one instance of it (action 1) and yields one result:
// twice the median, the number of values held, and is_wrong when a removal finds no match,
// an add finds the store full, or the store is empty afterwards (then median_doubled is 0 and
// the store is unchanged on a failed operation). In a transaction the row of cells compares and
// shifts in the accept cycle, the LOOKUP state registers the two middle entries, and the SUM
// state forms their sum into the output register. The output register holds its result while
// out_stall is high; a new sum waits in the SUM state until that register is free, and the next
// input is taken only once the sum has moved out. The store starts empty after reset and needs
// no clearing pass.
module running_median_add_remove_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                action,
  input  logic signed [rmar_pkg::DATA_W-1:0]  value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                is_wrong,
  output logic signed [rmar_pkg::MED_W-1:0]   median_doubled,
  output logic        [rmar_pkg::COUNT_W-1:0] element_count
);

  typedef enum logic [2:0] {
    IDLE   = 3'b001,
    LOOKUP = 3'b010,
    SUM    = 3'b100
  } state_t;

  state_t state, state_next;

  logic signed [rmar_pkg::DATA_W-1:0] cell_data [rmar_pkg::CAPACITY];
  rmar_pkg::flag_t                    cell_flag [rmar_pkg::CAPACITY];
  logic [rmar_pkg::CAPACITY-1:0]      hit_vec;
  logic [rmar_pkg::CAPACITY-1:0]      live_vec;

  logic [rmar_pkg::COUNT_W-1:0] count, count_next;
  logic                         err, err_next;
  logic signed [rmar_pkg::DATA_W-1:0] lo, hi;
  logic [rmar_pkg::COUNT_W-1:0] lo_wide, hi_wide;
  logic [rmar_pkg::IDX_W-1:0]   lo_idx, hi_idx;

  logic           accept, full, found, ok, load_out;
  rmar_pkg::cmd_t cmd;

  assign in_stall = (state != IDLE);
  assign accept   = in_valid && !in_stall;
  assign full     = (count == rmar_pkg::COUNT_W'(rmar_pkg::CAPACITY));
  assign found    = |hit_vec;
  assign ok       = (action == rmar_pkg::ACT_REMOVE) ? found : !full;

  always_comb begin
    cmd.remove_mode = (action == rmar_pkg::ACT_REMOVE);
    cmd.value       = value;
    cmd.add         = accept && (action == rmar_pkg::ACT_ADD) && !full;
    cmd.rem         = accept && (action == rmar_pkg::ACT_REMOVE) && found;
  end

  always_comb begin
    count_next = count;
    if (cmd.add) begin
      count_next = count + rmar_pkg::COUNT_W'(1);
    end else if (cmd.rem) begin
      count_next = count - rmar_pkg::COUNT_W'(1);
    end
    err_next = !ok || (count_next == '0);
  end

  genvar i;
  generate
    for (i = 0; i < rmar_pkg::CAPACITY; i++) begin : g_cell
      logic                              left_ge;
      logic signed [rmar_pkg::DATA_W-1:0] left_data;
      logic signed [rmar_pkg::DATA_W-1:0] right_data;

      assign live_vec[i] = (rmar_pkg::COUNT_W'(i) < count);
      assign hit_vec[i]  = cell_flag[i].hit;

      if (i == 0) begin : g_first
        assign left_ge   = 1'b0;
        assign left_data = value;
      end else begin : g_inner
        assign left_ge   = cell_flag[i-1].ge;
        assign left_data = cell_data[i-1];
      end

      if (i == rmar_pkg::CAPACITY - 1) begin : g_last
        assign right_data = cell_data[i];
      end else begin : g_body
        assign right_data = cell_data[i+1];
      end

      rmar_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .live       (live_vec[i]),
        .left_ge    (left_ge),
        .left_data  (left_data),
        .right_data (right_data),
        .data       (cell_data[i]),
        .flag       (cell_flag[i])
      );
    end
  endgenerate

  assign lo_wide = (count - rmar_pkg::COUNT_W'(1)) >> 1;
  assign hi_wide = count >> 1;
  assign lo_idx  = lo_wide[rmar_pkg::IDX_W-1:0];
  assign hi_idx  = hi_wide[rmar_pkg::IDX_W-1:0];

  assign load_out = (state == SUM) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    case (state)
      IDLE:    if (accept) state_next = LOOKUP;
      LOOKUP:  state_next = SUM;
      SUM:     if (load_out) state_next = IDLE;
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      err <= err_next;
    end
    if (state == LOOKUP) begin
      lo <= cell_data[lo_idx];
      hi <= cell_data[hi_idx];
    end
    if (load_out) begin
      is_wrong       <= err;
      element_count  <= count;
      median_doubled <= err ? '0 :
                        (rmar_pkg::MED_W'(lo) + rmar_pkg::MED_W'(hi));
    end
  end

endmodule

// ===== rtl/rmar_checker.sv =====
`include "assert_macros.svh"

module rmar_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic                                is_wrong,
  input logic signed [rmar_pkg::MED_W-1:0]   median_doubled,
  input logic        [rmar_pkg::COUNT_W-1:0] element_count
);

  `RMAR_ASSERT(a_wrong_zero, clk, rst,
               out_valid && is_wrong |-> median_doubled == '0,
               "error result carries a nonzero median")
  `RMAR_ASSERT(a_empty_wrong, clk, rst,
               out_valid && element_count == '0 |-> is_wrong,
               "empty store not flagged")
  `RMAR_ASSERT(a_count_cap, clk, rst,
               out_valid |-> element_count <= rmar_pkg::COUNT_W'(rmar_pkg::CAPACITY),
               "count beyond capacity")
  `RMAR_ASSERT(a_out_hold, clk, rst,
               out_valid && out_stall |=> out_valid && $stable(median_doubled) &&
               $stable(element_count),
               "stalled result changed")
  `RMAR_ASSERT(a_one_in_flight, clk, rst,
               in_valid && !in_stall |=> in_stall,
               "second transaction taken while busy")

endmodule

bind running_median_add_remove_core rmar_checker u_rmar_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .is_wrong       (is_wrong),
  .median_doubled (median_doubled),
  .element_count  (element_count)
);
